// ===== design/nfs_pkg.sv =====
// Shared types and constants for the n-gram fitness scorer.
// No dependencies; every other design and test file but nfs_table takes names from here.
package nfs_pkg;

  localparam int unsigned LETTER_W  = 5;
  localparam int unsigned ADDR_W    = 20;
  localparam int unsigned VALUE_W   = 24;
  localparam int unsigned SCORE_W   = 32;
  localparam int unsigned FRAC_BITS = 8;

  localparam logic CMD_WRITE  = 1'b0;
  localparam logic CMD_LETTER = 1'b1;

  // letter beat handed from the issue stage to the accumulator
  typedef struct packed {
    logic valid;
    logic lookup;
    logic word_end;
  } nfs_issue_t;

endpackage

// ===== design/nfs_if.sv =====
// Valid/ready channel interfaces for the scorer's input and result streams.
// Depends on nfs_pkg for the field widths.
interface nfs_in_if;
  logic                                valid;
  logic                                ready;
  logic                                cmd;
  logic [nfs_pkg::LETTER_W-1:0]        letter;
  logic                                word_end;
  logic [nfs_pkg::ADDR_W-1:0]          entry_address;
  logic signed [nfs_pkg::VALUE_W-1:0]  entry_value;

  modport source (output valid, cmd, letter, word_end, entry_address, entry_value,
                  input ready);
  modport sink   (input valid, cmd, letter, word_end, entry_address, entry_value,
                  output ready);
endinterface

interface nfs_out_if;
  logic                                valid;
  logic                                ready;
  logic signed [nfs_pkg::SCORE_W-1:0]  word_score;

  modport source (output valid, word_score, input ready);
  modport sink   (input valid, word_score, output ready);
endinterface

// ===== design/nfs_table.sv =====
// Frequency table: single write port, single read port, registered read data.
// Depends on nothing; widths come from the parent's parameters.
module nfs_table #(
  parameter int unsigned AW = 20,
  parameter int unsigned DW = 24
) (
  input  logic          clk_i,
  input  logic          wr_en_i,
  input  logic [AW-1:0] wr_addr_i,
  input  logic [DW-1:0] wr_data_i,
  input  logic          rd_en_i,
  input  logic [AW-1:0] rd_addr_i,
  output logic [DW-1:0] rd_data_o
);

  localparam logic [AW:0] Depth = (AW + 1)'(1) << AW;

  logic [DW-1:0] mem [Depth];
  logic [DW-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_data_q <= mem[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

// ===== design/nfs_accum.sv =====
// Accumulate stage: adds table entries to the word sum, truncating toward
// zero and saturating, and holds the result beat. Depends on nfs_pkg.
module nfs_accum #(
  parameter int unsigned ENTRY_BITS = 24
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  nfs_pkg::nfs_issue_t                 issue_i,
  input  logic signed [ENTRY_BITS-1:0]        entry_i,
  output logic                                ready_o,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic signed [nfs_pkg::SCORE_W-1:0]  word_score_o
);

  localparam int unsigned SW = nfs_pkg::SCORE_W;
  localparam int unsigned FB = nfs_pkg::FRAC_BITS;
  localparam int unsigned TW = SW + FB + 1;
  localparam int unsigned QW = TW - FB;
  localparam logic signed [TW-1:0] RoundBias = TW'((1 << FB) - 1);
  localparam logic signed [SW-1:0] SumMax = {1'b0, {(SW - 1){1'b1}}};
  localparam logic signed [SW-1:0] SumMin = {1'b1, {(SW - 1){1'b0}}};

  nfs_pkg::nfs_issue_t    s1_q;
  logic signed [SW-1:0]   sum_q, sum_d;
  logic                   out_valid_q;
  logic signed [SW-1:0]   score_q;

  logic                   stall;
  logic                   fire;
  logic signed [TW-1:0]   t_raw, t_adj;
  logic signed [QW-1:0]   quot;
  logic signed [SW-1:0]   added;

  assign stall   = s1_q.valid && s1_q.word_end && out_valid_q && !out_ready_i;
  assign fire    = s1_q.valid && !stall;
  assign ready_o = !stall;

  always_comb begin
    t_raw = (TW'(sum_q) <<< FB) + TW'(entry_i);
    t_adj = t_raw + (t_raw[TW-1] ? RoundBias : '0);
    quot  = $signed(t_adj[TW-1:FB]);
    if (quot[QW-1] != quot[QW-2]) begin
      added = quot[QW-1] ? SumMin : SumMax;
    end else begin
      added = quot[SW-1:0];
    end
    sum_d = s1_q.lookup ? added : sum_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_q        <= '0;
      sum_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (!stall) begin
        s1_q <= issue_i;
      end
      if (fire) begin
        sum_q <= s1_q.word_end ? '0 : sum_d;
      end
      if (fire && s1_q.word_end) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire && s1_q.word_end) begin
      score_q <= sum_d;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign word_score_o = score_q;

endmodule

// ===== design/ngram_fitness_scorer_core.sv =====
// N-gram log-frequency fitness scorer, top level.
// Depends on nfs_pkg, nfs_if, nfs_table and nfs_accum.
//
// in_i carries one command per beat. cmd write stores entry_value (signed,
// 8 fraction bits) at entry_address of the frequency table. cmd letter feeds
// one letter of a word; once NGRAM_LEN-1 letters are held, each letter looks
// up the window ending on it and adds the entry to the word sum, truncated
// toward zero and saturated to 32 bits. The letter flagged word_end closes
// the word and yields one beat on out_o with word_score; shorter words give 0.
//
// Throughput: one beat per cycle on in_i while in_i.ready is high, writes and
// letters alike. The table read of a letter is issued in its accept cycle and
// summed the cycle after in the accumulate stage, where a word_end letter sets
// the registered out_o.valid. The sum loop closes through one add in that stage.
// When out_o stalls, the result is held and letters keep flowing until a
// second word end reaches the accumulate stage; in_i.ready drops until the
// held result is taken. Reset clears the letter history, the sum and all
// valids; table contents are undefined until written and need no clearing.
module ngram_fitness_scorer_core #(
  parameter int unsigned NGRAM_LEN   = 4,
  parameter int unsigned LETTER_BITS = 5,
  parameter int unsigned ENTRY_BITS  = 24
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  nfs_in_if.sink    in_i,
  nfs_out_if.source out_o
);

  localparam int unsigned TBW   = NGRAM_LEN * LETTER_BITS;
  localparam int unsigned HW    = (NGRAM_LEN - 1) * LETTER_BITS;
  localparam int unsigned CW    = $clog2(NGRAM_LEN);
  localparam int unsigned Shift = (NGRAM_LEN - 2) * LETTER_BITS;
  localparam logic [CW-1:0] SeenFull = CW'(NGRAM_LEN - 1);

  logic [HW-1:0]          hist_q, hist_d;
  logic [CW-1:0]          seen_q, seen_d;
  logic                   accept;
  logic                   is_letter;
  logic                   lookup;
  logic [LETTER_BITS-1:0] letter_ext;
  logic [TBW-1:0]         rd_addr;
  logic [TBW-1:0]         wr_addr;
  logic signed [31:0]     value_ext;
  logic [ENTRY_BITS-1:0]  wr_data;
  logic [ENTRY_BITS-1:0]  rd_data;
  logic                   acc_ready;
  nfs_pkg::nfs_issue_t    issue;

  assign in_i.ready = acc_ready;
  assign accept     = in_i.valid && acc_ready;
  assign is_letter  = in_i.cmd == nfs_pkg::CMD_LETTER;
  assign lookup     = seen_q == SeenFull;
  assign letter_ext = LETTER_BITS'(in_i.letter);
  assign rd_addr    = {letter_ext, hist_q};
  assign wr_addr    = TBW'(in_i.entry_address);
  assign value_ext  = 32'(in_i.entry_value);
  assign wr_data    = value_ext[ENTRY_BITS-1:0];

  always_comb begin
    hist_d = (hist_q >> LETTER_BITS) | (HW'(letter_ext) << Shift);
    seen_d = lookup ? seen_q : seen_q + CW'(1);
    if (in_i.word_end) begin
      hist_d = '0;
      seen_d = '0;
    end
    issue.valid    = accept && is_letter;
    issue.lookup   = lookup;
    issue.word_end = in_i.word_end;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hist_q <= '0;
      seen_q <= '0;
    end else if (accept && is_letter) begin
      hist_q <= hist_d;
      seen_q <= seen_d;
    end
  end

  nfs_table #(
    .AW (TBW),
    .DW (ENTRY_BITS)
  ) u_table (
    .clk_i     (clk_i),
    .wr_en_i   (accept && !is_letter),
    .wr_addr_i (wr_addr),
    .wr_data_i (wr_data),
    .rd_en_i   (accept && is_letter && lookup),
    .rd_addr_i (rd_addr),
    .rd_data_o (rd_data)
  );

  nfs_accum #(
    .ENTRY_BITS (ENTRY_BITS)
  ) u_accum (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .issue_i      (issue),
    .entry_i      ($signed(rd_data)),
    .ready_o      (acc_ready),
    .out_valid_o  (out_o.valid),
    .out_ready_i  (out_o.ready),
    .word_score_o (out_o.word_score)
  );

endmodule

// ===== design/nfs_checker.sv =====
// Port-level checks for the scorer: result hold, result accounting and
// back-pressure cause. Depends on nfs_pkg and nfs_if; bound to the top level.
module nfs_checker (
  input  logic      clk_i,
  input  logic      rst_ni,
  nfs_in_if.sink    in_i,
  nfs_out_if.source out_o
);

  logic [1:0] pend_q, pend_d;
  logic       end_beat;
  logic       out_beat;

  assign end_beat = in_i.valid && in_i.ready && in_i.cmd == nfs_pkg::CMD_LETTER &&
                    in_i.word_end;
  assign out_beat = out_o.valid && out_o.ready;
  assign pend_d   = pend_q + 2'(end_beat) - 2'(out_beat);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q <= '0;
    end else begin
      pend_q <= pend_d;
    end
  end

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && !out_o.ready |=> out_o.valid && $stable(out_o.word_score))
    else $error("result beat dropped or changed while stalled");

  a_out_owed: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid |-> pend_q != 2'd0)
    else $error("result beat without a pending word end");

  a_pend_cap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_q != 2'd3)
    else $error("more than two word results in flight");

  a_bp_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_i.ready |-> out_o.valid && !out_o.ready)
    else $error("input stalled without a stalled result");

endmodule

bind ngram_fitness_scorer_core nfs_checker u_nfs_checker (
  .clk_i  (clk_i),
  .rst_ni (rst_ni),
  .in_i   (in_i),
  .out_o  (out_o)
);

// ===== test/nfs_score_checker.sv =====
// Checker for the n-gram fitness scorer: watches both channels, predicts each
// word score and compares it with the result beats. Depends on nfs_pkg, nfs_if.
module nfs_score_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  nfs_in_if           in_i,
  nfs_out_if          out_i,
  output int unsigned fail_count_o,
  output int unsigned pending_o,
  output int unsigned scores_checked_o
);
  timeunit 1ns;
  timeprecision 1ps;
  import nfs_pkg::*;

  localparam int unsigned Ngram    = 4;
  localparam longint      ScoreMax = (longint'(1) <<< (SCORE_W - 1)) - 1;
  localparam longint      ScoreMin = -(longint'(1) <<< (SCORE_W - 1));

  logic signed [VALUE_W-1:0]        freq_table [logic [ADDR_W-1:0]];
  logic [(Ngram-1)*LETTER_W-1:0]    recent_letters;
  logic [ADDR_W-1:0]                window_idx;
  int unsigned                      window_fill;
  logic signed [SCORE_W-1:0]        word_sum;
  logic signed [SCORE_W-1:0]        expected_scores [$];
  logic signed [SCORE_W-1:0]        want;
  int unsigned                      fails = 0;
  int unsigned                      checked = 0;

  // sum + entry/256, truncated toward zero, then clamped to 32 bits
  function automatic logic signed [SCORE_W-1:0] add_window(
    input logic signed [SCORE_W-1:0] acc,
    input logic signed [VALUE_W-1:0] entry
  );
    longint scaled;
    longint whole;
    scaled = longint'(acc) * (longint'(1) << FRAC_BITS) + longint'(entry);
    whole  = scaled / (longint'(1) << FRAC_BITS);
    if (whole > ScoreMax) whole = ScoreMax;
    if (whole < ScoreMin) whole = ScoreMin;
    return SCORE_W'(whole);
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      recent_letters = '0;
      window_fill    = 0;
      word_sum       = '0;
      expected_scores.delete();
    end else begin
      if (out_i.valid && out_i.ready) begin
        checked++;
        if (expected_scores.size() == 0) begin
          fails++;
          $display("%0t: word_score expected none, actual %0d", $time, out_i.word_score);
        end else begin
          want = expected_scores.pop_front();
          if (out_i.word_score !== want) begin
            fails++;
            $display("%0t: word_score expected %0d, actual %0d",
                     $time, want, out_i.word_score);
          end
        end
      end
      if (in_i.valid && in_i.ready) begin
        if (in_i.cmd == CMD_WRITE) begin
          freq_table[in_i.entry_address] = in_i.entry_value;
        end else begin
          if (window_fill >= Ngram - 1) begin
            window_idx = {in_i.letter, recent_letters};
            word_sum   = add_window(word_sum,
                                    freq_table.exists(window_idx) ? freq_table[window_idx] : '0);
          end else begin
            window_fill++;
          end
          recent_letters = {in_i.letter, recent_letters[(Ngram-1)*LETTER_W-1:LETTER_W]};
          if (in_i.word_end) begin
            expected_scores.push_back(word_sum);
            word_sum       = '0;
            recent_letters = '0;
            window_fill    = 0;
          end
        end
      end
    end
    fail_count_o     <= fails;
    pending_o        <= expected_scores.size();
    scores_checked_o <= checked;
  end

endmodule

// ===== test/tb_top.sv =====
// Top of the n-gram fitness scorer testbench: clock, reset, stimulus, result
// stalls and verdict. Depends on nfs_pkg, nfs_if, the scorer core and the checker.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import nfs_pkg::*;

  typedef logic [LETTER_W-1:0] letter_t;

  localparam int unsigned Ngram       = 4;
  localparam int unsigned HoldCycles  = 300;
  localparam int unsigned RandomBeats = 1300;
  localparam int unsigned LongLetters = 64;

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        hold_results = 1'b0;
  bit          in_gaps = 1'b1;
  bit          out_gaps = 1'b1;
  int unsigned fail_count, pending_scores, scores_checked;
  int unsigned beats_sent = 0;
  int unsigned table_writes = 0;
  int unsigned words_sent = 0;
  bit          entry_known [logic [ADDR_W-1:0]];
  letter_t     alphabet [4];

  nfs_in_if  score_in ();
  nfs_out_if score_out ();

  ngram_fitness_scorer_core i_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (score_in),
    .out_o  (score_out)
  );

  nfs_score_checker i_checker (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_i             (score_in),
    .out_i            (score_out),
    .fail_count_o     (fail_count),
    .pending_o        (pending_scores),
    .scores_checked_o (scores_checked)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  initial begin
    #10ms;
    $display("[FAIL] regression broken");
    $finish;
  end

  initial begin
    score_out.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_results) begin
        score_out.ready <= 1'b0;
        repeat (HoldCycles) @(posedge clk_i);
        hold_results <= 1'b0;
      end else if (out_gaps && $urandom_range(0, 5) == 0) begin
        score_out.ready <= 1'b0;
        repeat ($urandom_range(1, 16)) @(posedge clk_i);
      end else begin
        score_out.ready <= 1'b1;
      end
    end
  end

  task automatic offer_beat(input logic cmd, input letter_t letter, input logic last,
                            input logic [ADDR_W-1:0] addr,
                            input logic signed [VALUE_W-1:0] value);
    if (in_gaps && $urandom_range(0, 3) == 0) begin
      score_in.valid <= 1'b0;
      repeat ($urandom_range(1, 16)) @(posedge clk_i);
    end
    score_in.valid         <= 1'b1;
    score_in.cmd           <= cmd;
    score_in.letter        <= letter;
    score_in.word_end      <= last;
    score_in.entry_address <= addr;
    score_in.entry_value   <= value;
    @(posedge clk_i);
    while (!score_in.ready) @(posedge clk_i);
    beats_sent++;
  endtask

  task automatic write_entry(input logic [ADDR_W-1:0] addr,
                             input logic signed [VALUE_W-1:0] value);
    offer_beat(CMD_WRITE, letter_t'($urandom_range(0, 31)), 1'($urandom_range(0, 1)),
               addr, value);
    entry_known[addr] = 1'b1;
    table_writes++;
  endtask

  // any window not yet in the table gets a random entry written just before
  // the letter that reads it, i.e. in the middle of the word
  task automatic score_word(input letter_t text[$]);
    logic [(Ngram-1)*LETTER_W-1:0] held;
    logic [ADDR_W-1:0]             idx;
    held = '0;
    foreach (text[i]) begin
      if (i >= Ngram - 1) begin
        idx = {text[i], held};
        if (!entry_known.exists(idx)) write_entry(idx, VALUE_W'($urandom()));
      end
      offer_beat(CMD_LETTER, text[i], i == text.size() - 1,
                 ADDR_W'($urandom()), VALUE_W'($urandom()));
      held = {text[i], held[(Ngram-1)*LETTER_W-1:LETTER_W]};
    end
    words_sent++;
  endtask

  task automatic random_word(input int unsigned len, input bit common);
    letter_t text[$];
    repeat (len) begin
      text.push_back(common ? alphabet[$urandom_range(0, 3)] : letter_t'($urandom_range(0, 31)));
    end
    score_word(text);
  endtask

  initial begin
    letter_t     text[$];
    int unsigned random_start;
    bit          pressed;
    pressed                = 1'b0;
    rst_ni                 = 1'b0;
    score_in.valid         <= 1'b0;
    score_in.cmd           <= CMD_WRITE;
    score_in.letter        <= '0;
    score_in.word_end      <= 1'b0;
    score_in.entry_address <= '0;
    score_in.entry_value   <= '0;
    foreach (alphabet[i]) alphabet[i] = letter_t'($urandom_range(0, 31));
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;

    // extremes, short words, truncation toward zero
    write_entry('0, 24'sh7fffff);
    write_entry('1, 24'sh800000);
    score_word('{0, 0, 0, 0});
    score_word('{31, 31, 31, 31, 31});
    score_word('{5});
    score_word('{6, 7});
    score_word('{8, 9, 10});
    write_entry({5'd4, 5'd3, 5'd2, 5'd1}, 24'sd383);
    write_entry({5'd5, 5'd4, 5'd3, 5'd2}, -24'sd257);
    score_word('{1, 2, 3, 4, 5});
    score_word('{9, 17, 25, 3, 12});

    random_start = beats_sent;
    while (beats_sent < random_start + RandomBeats) begin
      if ($urandom_range(0, 19) == 0) in_gaps = !in_gaps;
      if ($urandom_range(0, 19) == 0) out_gaps = !out_gaps;
      if ($urandom_range(0, 15) == 0) begin
        foreach (alphabet[i]) alphabet[i] = letter_t'($urandom_range(0, 31));
      end
      if (!pressed && beats_sent >= random_start + RandomBeats / 2) begin
        // results held back while short words keep coming: input must stall
        pressed = 1'b1;
        hold_results <= 1'b1;
        repeat (12) random_word(4, 1'b1);
      end else if ($urandom_range(0, 9) == 0) begin
        write_entry(ADDR_W'($urandom()), VALUE_W'($urandom()));
      end else begin
        random_word($urandom_range(0, 9) < 8 ? $urandom_range(1, 10) : $urandom_range(11, 40),
                    1'($urandom_range(0, 1)));
      end
    end

    // long words on the extreme entries, no gaps from here on
    in_gaps  = 1'b0;
    out_gaps = 1'b0;
    write_entry('0, 24'sh7fffff);
    write_entry('1, 24'sh800000);
    repeat (LongLetters) text.push_back('0);
    repeat (Ngram) text.push_back('1);
    score_word(text);
    text.delete();
    repeat (LongLetters) text.push_back('1);
    score_word(text);

    score_in.valid <= 1'b0;
    @(posedge clk_i);
    while (pending_scores != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);

    $display("Covered %0d beats: %0d table writes, %0d words, %0d scores compared.",
             beats_sent, table_writes, words_sent, scores_checked);
    $display("Included short words, writes inside words, long words on extreme entries and a %0d-cycle hold.",
             HoldCycles);
    if (fail_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
design/nfs_pkg.sv
design/nfs_if.sv
design/nfs_table.sv
design/nfs_accum.sv
design/ngram_fitness_scorer_core.sv
design/nfs_checker.sv
test/nfs_score_checker.sv
test/tb_top.sv
